FILE: rtl/ppba_pkg.sv
package ppba_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_PAGES  = 16;

    // field widths fixed by the interface
    localparam int ALIGN_W = 12;
    localparam int SIZE_W  = 13;
    localparam int PROT_W  = 3;
    localparam int PIDX_W  = 4;
    localparam int OFF_W   = 13;

    // internal widths
    localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int USED_W = $clog2(PAGE_BYTES + 1);
    localparam int SUM_W = USED_W + 1;

    typedef enum logic [1:0] {
        ST_FIT  = 2'd0,
        ST_NEW  = 2'd1,
        ST_FULL = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [ALIGN_W-1:0] align_bytes;
        logic [SIZE_W-1:0]  req_size;
        logic [PROT_W-1:0]  prot_class;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [PIDX_W-1:0] page_index;
        logic [OFF_W-1:0]  alloc_offset;
    } rsp_t;

    typedef struct packed {
        logic [PROT_W-1:0] prot;
        logic [USED_W-1:0] used;
    } entry_t;

endpackage

FILE: rtl/ppba_ram.sv
module ppba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/protection_pooled_page_bump_alloc_unit.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_data (req_t: align_bytes, req_size, prot_class)
// m_       out  m_valid/m_ready    m_data (rsp_t: status, page_index, alloc_offset)
//
// One request at a time: accept, check, then one page table entry per cycle
// through the table RAM (one read port, one write port) until a page fits or
// the open pages run out, then load the result register. A bad request or an
// empty table goes straight from the check to the load.
// Reset (aresetn low, synchronous) empties the table by clearing the open
// page count; entries at or above it are never read.
// A held result stalls the final load, and no new request is taken meanwhile.
module protection_pooled_page_bump_alloc_unit
    import ppba_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    state_t state_reg, state_next;
    req_t   req_reg;
    rsp_t   res_reg, res_next;
    rsp_t   m_data_reg;
    logic   m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] open_reg, open_next;
    logic [CNT_W-1:0] scan_reg, scan_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    entry_t            ram_wdata, rd_entry;

    logic              out_free;
    logic              bad_req;
    logic              fit;
    logic              last;
    logic              room;
    logic [SUM_W-1:0]  align_mask;
    logic [SUM_W-1:0]  aligned;
    logic [SUM_W-1:0]  end_pos;

    ppba_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_PAGES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    assign out_free = !m_valid_reg || m_ready;

    assign bad_req = (req_reg.align_bytes == '0)
        || ((req_reg.align_bytes & (req_reg.align_bytes - ALIGN_W'(1))) != '0)
        || (SUM_W'(req_reg.align_bytes) >= SUM_W'(PAGE_BYTES))
        || (SUM_W'(req_reg.req_size) > SUM_W'(PAGE_BYTES));

    // power-of-two alignment: round up with a mask
    assign align_mask = SUM_W'(req_reg.align_bytes) - SUM_W'(1);
    assign aligned    = (SUM_W'(rd_entry.used) + align_mask) & ~align_mask;
    assign end_pos    = aligned + SUM_W'(req_reg.req_size);
    assign fit        = (rd_entry.prot == req_reg.prot_class)
                        && (end_pos <= SUM_W'(PAGE_BYTES));
    assign last       = (scan_reg + CNT_W'(1)) == open_reg;
    assign room       = open_reg < CNT_W'(MAX_PAGES);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (bad_req || open_reg == '0) state_next = S_EMIT;
                else state_next = S_SCAN;
            end
            S_SCAN: begin
                if (fit || last) state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = open_reg[IDX_W-1:0];
        ram_wdata    = '{prot: req_reg.prot_class, used: USED_W'(req_reg.req_size)};
        ram_raddr    = '0;
        res_next     = res_reg;
        scan_next    = scan_reg;
        open_next    = open_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_CHECK: begin
                scan_next = '0;
                if (bad_req) begin
                    res_next = '{status: ST_BAD, page_index: '0, alloc_offset: '0};
                end else if (open_reg == '0) begin
                    ram_we    = 1'b1;
                    open_next = open_reg + CNT_W'(1);
                    res_next  = '{status: ST_NEW, page_index: PIDX_W'(open_reg),
                                  alloc_offset: '0};
                end
            end
            S_SCAN: begin
                ram_raddr = scan_next[IDX_W-1:0];
                if (fit) begin
                    ram_we         = 1'b1;
                    ram_waddr      = scan_reg[IDX_W-1:0];
                    ram_wdata.prot = rd_entry.prot;
                    ram_wdata.used = end_pos[USED_W-1:0];
                    res_next       = '{status: ST_FIT, page_index: PIDX_W'(scan_reg),
                                       alloc_offset: OFF_W'(aligned)};
                end else if (last) begin
                    if (room) begin
                        ram_we    = 1'b1;
                        open_next = open_reg + CNT_W'(1);
                        res_next  = '{status: ST_NEW, page_index: PIDX_W'(open_reg),
                                      alloc_offset: '0};
                    end else begin
                        res_next = '{status: ST_FULL, page_index: '0, alloc_offset: '0};
                    end
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                    ram_raddr = scan_next[IDX_W-1:0];
                end
            end
            S_EMIT: begin
                if (out_free) m_valid_next = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            open_reg    <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) req_reg <= s_data;
        res_reg <= res_next;
        if (state_reg == S_EMIT && out_free) m_data_reg <= res_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= CNT_W'(MAX_PAGES))
        else $error("open page count above table size");

    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CHECK || state_reg == S_SCAN))
        else $error("table write outside check or scan");

    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && !fit && !last)
            |=> (state_reg == S_SCAN && scan_reg == $past(scan_reg) + CNT_W'(1)))
        else $error("scan did not advance by one entry");

    a_fit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && res_reg.status == ST_FIT)
            |-> (CNT_W'(res_reg.page_index) < open_reg))
        else $error("fit reported on an unopened page");
`endif

endmodule

FILE: dv/protection_pooled_page_bump_alloc_unit_test.sv
`timescale 1ns / 100ps

module protection_pooled_page_bump_alloc_unit_test;
    import ppba_pkg::*;

    localparam int RANDOM_REQS = 600;
    localparam int CALM_TAIL   = 80;    // last requests run with no idling
    localparam int HOLD_AT     = 120;   // result count that starts the long hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        req_t rq;
        bit   drain;    // wait until every expected result is back before offering
    } queued_req_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    queued_req_t pending_reqs[$];
    rsp_t        expected_allocs[$];

    // shadow page table
    logic [PROT_W-1:0] page_prot [MAX_PAGES];
    int unsigned       page_used [MAX_PAGES];
    int unsigned       open_pages = 0;

    int unsigned failures   = 0;
    int unsigned sent_count = 0;
    int unsigned got_count  = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;

    protection_pooled_page_bump_alloc_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic rsp_t predict_alloc(req_t rq);
        rsp_t        r;
        int unsigned al;
        int unsigned sz;
        int unsigned start;
        int unsigned k;
        r.status       = ST_BAD;
        r.page_index   = '0;
        r.alloc_offset = '0;
        al = rq.align_bytes;
        sz = rq.req_size;
        if (al == 0 || (al & (al - 1)) != 0 || al >= PAGE_BYTES || sz > PAGE_BYTES)
            return r;
        for (k = 0; k < open_pages; k++) begin
            if (page_prot[k] == rq.prot_class) begin
                start = ((page_used[k] + al - 1) / al) * al;
                if (start <= PAGE_BYTES && PAGE_BYTES - start >= sz) begin
                    page_used[k]   = start + sz;
                    r.status       = ST_FIT;
                    r.page_index   = PIDX_W'(k);
                    r.alloc_offset = OFF_W'(start);
                    return r;
                end
            end
        end
        if (open_pages < MAX_PAGES) begin
            page_prot[open_pages] = rq.prot_class;
            page_used[open_pages] = sz;
            r.status              = ST_NEW;
            r.page_index          = PIDX_W'(open_pages);
            open_pages++;
            return r;
        end
        r.status = ST_FULL;
        return r;
    endfunction

    function automatic bit calm();
        return pending_reqs.size() < CALM_TAIL;
    endfunction

    task automatic queue_req(int unsigned al, int unsigned sz, int unsigned pr, bit drain);
        queued_req_t q;
        q.rq.align_bytes = ALIGN_W'(al);
        q.rq.req_size    = SIZE_W'(sz);
        q.rq.prot_class  = PROT_W'(pr);
        q.drain          = drain;
        pending_reqs.push_back(q);
    endtask

    // request driver
    always @(posedge aclk) begin : drive_req
        bit holding;
        queued_req_t q;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            gap_left <= 0;
        end else begin
            holding = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                expected_allocs.push_back(predict_alloc(s_data));
                sent_count++;
            end
            if (!holding) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_reqs[0].drain && expected_allocs.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (!calm() && $urandom_range(0, 9) == 0) begin
                    gap_left <= $urandom_range(0, 7);
                    s_valid  <= 1'b0;
                end else begin
                    q = pending_reqs.pop_front();
                    s_data  <= q.rq;
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // result monitor and ready generation
    always @(posedge aclk) begin : watch_rsp
        bit   fire;
        rsp_t exp_r;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else begin
            fire = m_valid && m_ready;
            if (fire) begin
                got_count++;
                if (expected_allocs.size() == 0) begin
                    $error("unexpected result: status %0d page_index %0d alloc_offset %0d",
                           m_data.status, m_data.page_index, m_data.alloc_offset);
                    failures++;
                end else begin
                    exp_r = expected_allocs.pop_front();
                    if (m_data.status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, m_data.status);
                        failures++;
                    end
                    if (m_data.page_index !== exp_r.page_index) begin
                        $error("page_index: expected %0d, actual %0d",
                               exp_r.page_index, m_data.page_index);
                        failures++;
                    end
                    if (m_data.alloc_offset !== exp_r.alloc_offset) begin
                        $error("alloc_offset: expected %0d, actual %0d",
                               exp_r.alloc_offset, m_data.alloc_offset);
                        failures++;
                    end
                end
            end
            if (fire && got_count == HOLD_AT) begin
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (!calm() && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 7);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int i;
        int unsigned al;
        int unsigned sz;
        int unsigned pick;

        // directed: bad requests, edges of size and alignment, each class
        queue_req(1, 0, 0, 1'b0);           // opens page 0 with nothing used
        queue_req(0, 10, 0, 1'b0);          // zero alignment
        queue_req(3, 10, 1, 1'b0);          // alignment not a power of two
        queue_req(4095, 4096, 7, 1'b0);     // all-ones alignment
        queue_req(2048, 4097, 2, 1'b0);     // size just over a page
        queue_req(1, 8191, 3, 1'b0);        // all-ones size
        queue_req(2048, 4096, 7, 1'b0);     // full page in a new entry
        queue_req(1, 4096, 0, 1'b0);        // fills page 0 exactly
        queue_req(2048, 0, 0, 1'b0);        // zero size at the page end
        queue_req(1, 1, 0, 1'b0);           // page 0 full, new entry
        queue_req(16, 5, 1, 1'b0);
        queue_req(64, 3, 1, 1'b0);          // rounds used count up to 64
        queue_req(2048, 100, 2, 1'b0);
        queue_req(2048, 1, 2, 1'b0);        // lands at 2048
        queue_req(2048, 2048, 2, 1'b0);     // no room left, new entry
        queue_req(8, 4000, 3, 1'b1);        // offered only after a full drain
        queue_req(4, 97, 3, 1'b0);
        queue_req(32, 12, 4, 1'b0);
        queue_req(128, 1, 5, 1'b0);
        queue_req(1024, 33, 6, 1'b0);
        queue_req(512, 4096, 7, 1'b0);

        for (i = 0; i < RANDOM_REQS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                al = 1 << $urandom_range(0, ALIGN_W - 1);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    sz = $urandom_range(0, 64);
                else if (pick < 90)
                    sz = $urandom_range(0, 1024);
                else if (pick < 95)
                    sz = $urandom_range(0, PAGE_BYTES);
                else
                    sz = PAGE_BYTES;
            end else begin
                al = $urandom_range(0, (1 << ALIGN_W) - 1);
                sz = $urandom_range(0, (1 << SIZE_W) - 1);
            end
            queue_req(al, sz, $urandom_range(0, 7), i == RANDOM_REQS / 2);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_allocs.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (failures == 0 && expected_allocs.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/ppba_pkg.sv
rtl/ppba_ram.sv
rtl/protection_pooled_page_bump_alloc_unit.sv
dv/protection_pooled_page_bump_alloc_unit_test.sv
